/* rtl/aicx_pkg.sv */
// Shared types and constants for the APIC ID to complex table engine.
// Used by the front, queue, back and top level; no dependencies.
package aicx_pkg;

    // Default table depth
    localparam int TABLE_DEPTH_DEF = 512;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOPOLOGY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMT      = 2'd1;

    // Table entry: valid mark in bit 7, socket in 5:4, complex in 3:0
    localparam logic [7:0] ENTRY_VALID = 8'h80;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_MERGE  = 2'd2,
        REQ_LOOKUP = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CONFLICT = 3'd1,
        ST_PLATFORM = 3'd2,
        ST_PARAMS   = 3'd3,
        ST_ENTRY    = 3'd4
    } status_t;

    // Classified item handed from front to back
    typedef struct packed {
        req_t        op;
        logic        plat_err;   // bad topology or index out of range
        logic [31:0] addr;       // thread-zero ID on insert, id_index otherwise
        logic        addr_ok;    // addr below table depth
        logic        addr1_ok;   // addr | 1 below table depth
        logic        smt;
        logic [7:0]  entry;      // entry to store (insert) or peer entry (merge)
        logic        peer_dis;
        logic        last;
    } cmd_t;

endpackage

/* rtl/aicx_front.sv */
// Front end: configuration registers, ID layout decode and item classification.
// Depends on aicx_pkg.
module aicx_front #(
    parameter int TABLE_DEPTH = aicx_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [aicx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic [1:0]                     req_type,
    input  logic [31:0]                    core_info,
    input  logic [3:0]                     phys_complex,
    input  logic [31:0]                    id_index,
    input  logic [7:0]                     peer_entry,
    input  logic                           peer_disabled,
    input  logic                           last,
    output aicx_pkg::cmd_t                 cmd
);

    logic [31:0] topo_reg;
    logic        smt_reg;

    logic [3:0]  core_max;
    logic        ccx_max;
    logic [3:0]  die_max;
    logic [1:0]  sock_max;
    logic        pad16;
    logic [3:0]  core_sh;
    logic [3:0]  bp1;
    logic [3:0]  ccx_sh;
    logic [3:0]  die_sh;
    logic [3:0]  sock_sh;
    logic        layout_ok;
    logic [1:0]  sock;
    logic [3:0]  die;
    logic        ccx;
    logic [3:0]  core;
    logic        range_bad;
    logic [31:0] id0;
    logic [31:0] addr;
    aicx_pkg::req_t op;

    function automatic logic [2:0] bit_len4(input logic [3:0] v);
        logic [2:0] n;
        if (v[3])
            n = 3'd4;
        else if (v[2])
            n = 3'd3;
        else if (v[1])
            n = 3'd2;
        else if (v[0])
            n = 3'd1;
        else
            n = 3'd0;
        return n;
    endfunction

    // Configuration registers; write them only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            topo_reg <= '0;
            smt_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                aicx_pkg::CFG_TOPOLOGY: topo_reg <= cfg_data;
                aicx_pkg::CFG_SMT:      smt_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Field positions of an APIC ID
    assign core_max = topo_reg[19:16];
    assign ccx_max  = topo_reg[20];
    assign die_max  = topo_reg[24:21];
    assign sock_max = topo_reg[26:25];
    assign pad16    = topo_reg[11];

    assign core_sh = {3'b000, smt_reg};
    assign bp1     = core_sh + {1'b0, bit_len4(core_max)};
    assign ccx_sh  = (pad16 && (bp1 < 4'd4)) ? 4'd4 : bp1;
    assign die_sh  = ccx_sh + {3'b000, ccx_max};
    assign sock_sh = die_sh + {1'b0, bit_len4(die_max)};
    // The fields total at most 12 bits, so only an all-zero word is bad
    assign layout_ok = (topo_reg != 32'd0) && (sock_max <= 2'd3);

    // Per-core word fields
    assign sock = core_info[13:12];
    assign die  = core_info[22:19];
    assign ccx  = core_info[18];
    assign core = core_info[17:14];

    assign range_bad = (core > core_max) || (die > die_max);

    assign id0 = (32'(core) << core_sh) | (32'(die) << die_sh) | (32'(sock) << sock_sh)
               | (ccx_max ? (32'(ccx) << ccx_sh) : 32'd0);

    assign op   = aicx_pkg::req_t'(req_type);
    assign addr = (op == aicx_pkg::REQ_INSERT) ? id0 : id_index;

    // Classified item
    always_comb
    begin
        cmd          = '0;
        cmd.op       = op;
        cmd.addr     = addr;
        cmd.addr_ok  = addr < 32'(TABLE_DEPTH);
        cmd.addr1_ok = (addr | 32'd1) < 32'(TABLE_DEPTH);
        cmd.smt      = smt_reg;
        cmd.peer_dis = peer_disabled;
        cmd.last     = last;
        unique case (op)
            aicx_pkg::REQ_CLEAR:
                cmd.plat_err = !layout_ok;
            aicx_pkg::REQ_INSERT:
            begin
                cmd.plat_err = !layout_ok || range_bad;
                cmd.entry    = aicx_pkg::ENTRY_VALID | {2'b00, sock, phys_complex};
            end
            aicx_pkg::REQ_MERGE:
                cmd.entry = peer_entry;
            aicx_pkg::REQ_LOOKUP:
                cmd.plat_err = 1'b0;
        endcase
    end

endmodule

/* rtl/aicx_queue.sv */
// Short command queue between front and back.
// Depends on aicx_pkg.
module aicx_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  aicx_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output aicx_pkg::cmd_t pop_cmd
);

    localparam int PTR_W = (aicx_pkg::QUEUE_DEPTH > 1) ? $clog2(aicx_pkg::QUEUE_DEPTH) : 1;

    aicx_pkg::cmd_t   slot_reg [aicx_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != (PTR_W+1)'(aicx_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(aicx_pkg::QUEUE_DEPTH - 1)) ? '0
                            : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(aicx_pkg::QUEUE_DEPTH - 1)) ? '0
                            : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* rtl/aicx_back.sv */
// Back end: ID table memory, sequencer for clear/insert/merge/lookup, result register.
// Depends on aicx_pkg.
module aicx_back #(
    parameter int TABLE_DEPTH = aicx_pkg::TABLE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  aicx_pkg::cmd_t q_cmd,
    output logic           init_busy,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [2:0]     status,
    output logic [31:0]    computed_id,
    output logic [63:0]    complex_mask,
    output logic           activation_ok,
    output logic           list_done
);

    localparam int AW = $clog2(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_RDA,
        S_RDB,
        S_WRB
    } state_t;

    logic [7:0] mem [TABLE_DEPTH];
    logic [7:0] rd_data_reg;

    state_t            state_reg,   state_next;
    logic [AW-1:0]     sweep_reg,   sweep_next;
    logic              sw_clr_reg,  sw_clr_next;
    logic              init_reg,    init_next;
    aicx_pkg::cmd_t    cmd_reg,     cmd_next;
    logic              conflict_reg, conflict_next;
    logic [63:0]       mask_reg,    mask_next;
    aicx_pkg::status_t lerr_reg,    lerr_next;
    logic              ov_reg,      ov_next;
    aicx_pkg::status_t st_reg,      st_next;
    logic [31:0]       cid_reg,     cid_next;
    logic [63:0]       cmask_reg,   cmask_next;
    logic              act_reg,     act_next;
    logic              done_reg,    done_next;

    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic [7:0]        wdata;
    logic              pop;
    logic              fin;
    aicx_pkg::status_t fin_st;
    aicx_pkg::cmd_t    fin_cmd;
    logic [AW-1:0]     addr0;
    logic [AW-1:0]     addr1;

    assign addr0 = cmd_reg.addr[AW-1:0];
    assign addr1 = {cmd_reg.addr[AW-1:1], 1'b1};

    // Table memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        if (mem_re)
            rd_data_reg <= mem[raddr];
    end

    // Sequencer and result next-state logic
    always_comb
    begin
        state_next    = state_reg;
        sweep_next    = sweep_reg;
        sw_clr_next   = sw_clr_reg;
        init_next     = init_reg;
        cmd_next      = cmd_reg;
        conflict_next = conflict_reg;
        mask_next     = mask_reg;
        lerr_next     = lerr_reg;
        ov_next       = ov_reg;
        st_next       = st_reg;
        cid_next      = cid_reg;
        cmask_next    = cmask_reg;
        act_next      = act_reg;
        done_next     = done_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        waddr         = '0;
        raddr         = '0;
        wdata         = '0;
        pop           = 1'b0;
        fin           = 1'b0;
        fin_st        = aicx_pkg::ST_OK;
        fin_cmd       = cmd_reg;

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        unique case (state_reg)
            // Zero one entry a cycle, after reset or for a clear item
            S_SWEEP:
            begin
                mem_we = 1'b1;
                waddr  = sweep_reg;
                if (sweep_reg == AW'(TABLE_DEPTH - 1))
                begin
                    sweep_next = '0;
                    init_next  = 1'b0;
                    state_next = S_IDLE;
                    if (sw_clr_reg)
                    begin
                        conflict_next = 1'b0;
                        fin           = 1'b1;
                    end
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            // Take the next item once the result register is free
            S_IDLE:
            begin
                if (q_valid && !ov_reg)
                begin
                    pop      = 1'b1;
                    cmd_next = q_cmd;
                    fin_cmd  = q_cmd;
                    raddr    = q_cmd.addr[AW-1:0];
                    unique case (q_cmd.op)
                        aicx_pkg::REQ_CLEAR:
                        begin
                            if (q_cmd.plat_err)
                            begin
                                fin    = 1'b1;
                                fin_st = aicx_pkg::ST_PLATFORM;
                            end
                            else
                            begin
                                sw_clr_next = 1'b1;
                                state_next  = S_SWEEP;
                            end
                        end
                        aicx_pkg::REQ_INSERT:
                        begin
                            if (q_cmd.plat_err)
                            begin
                                fin    = 1'b1;
                                fin_st = aicx_pkg::ST_PLATFORM;
                            end
                            else if (conflict_reg)
                            begin
                                fin    = 1'b1;
                                fin_st = aicx_pkg::ST_CONFLICT;
                            end
                            else if (!q_cmd.addr_ok)
                            begin
                                conflict_next = 1'b1;
                                fin           = 1'b1;
                                fin_st        = aicx_pkg::ST_CONFLICT;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = S_RDA;
                            end
                        end
                        aicx_pkg::REQ_MERGE:
                        begin
                            fin = 1'b1;
                            if (q_cmd.peer_dis)
                            begin
                                conflict_next = 1'b1;
                                fin_st        = aicx_pkg::ST_CONFLICT;
                            end
                            else if (conflict_reg)
                                fin_st = aicx_pkg::ST_CONFLICT;
                            else if (!q_cmd.addr_ok)
                                fin_st = aicx_pkg::ST_PARAMS;
                            else if (q_cmd.entry != 8'd0)
                            begin
                                fin        = 1'b0;
                                mem_re     = 1'b1;
                                state_next = S_RDA;
                            end
                        end
                        aicx_pkg::REQ_LOOKUP:
                        begin
                            if (lerr_reg != aicx_pkg::ST_OK)
                            begin
                                fin    = 1'b1;
                                fin_st = lerr_reg;
                            end
                            else if (!q_cmd.addr_ok)
                            begin
                                lerr_next = aicx_pkg::ST_PARAMS;
                                fin       = 1'b1;
                                fin_st    = aicx_pkg::ST_PARAMS;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = S_RDA;
                            end
                        end
                    endcase
                end
            end

            // First table read has returned
            S_RDA:
            begin
                state_next = S_IDLE;
                priority case (cmd_reg.op)
                    aicx_pkg::REQ_INSERT:
                    begin
                        if (rd_data_reg != 8'd0)
                        begin
                            conflict_next = 1'b1;
                            fin           = 1'b1;
                            fin_st        = aicx_pkg::ST_CONFLICT;
                        end
                        else if (cmd_reg.smt)
                        begin
                            if (!cmd_reg.addr1_ok)
                            begin
                                conflict_next = 1'b1;
                                fin           = 1'b1;
                                fin_st        = aicx_pkg::ST_CONFLICT;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                raddr      = addr1;
                                state_next = S_RDB;
                            end
                        end
                        else
                        begin
                            mem_we = 1'b1;
                            waddr  = addr0;
                            wdata  = cmd_reg.entry;
                            fin    = 1'b1;
                        end
                    end
                    aicx_pkg::REQ_MERGE:
                    begin
                        fin = 1'b1;
                        if (rd_data_reg != 8'd0)
                        begin
                            conflict_next = 1'b1;
                            fin_st        = aicx_pkg::ST_CONFLICT;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                            waddr  = addr0;
                            wdata  = cmd_reg.entry;
                        end
                    end
                    aicx_pkg::REQ_LOOKUP:
                    begin
                        fin = 1'b1;
                        if (!rd_data_reg[7])
                        begin
                            lerr_next = aicx_pkg::ST_ENTRY;
                            fin_st    = aicx_pkg::ST_ENTRY;
                        end
                        else if (!rd_data_reg[6])
                        begin
                            // complex numbers of 64 and up add nothing
                            mask_next = mask_reg | (64'd1 << rd_data_reg[5:0]);
                        end
                    end
                    default: ;
                endcase
            end

            // Odd-thread read has returned
            S_RDB:
            begin
                if (rd_data_reg != 8'd0)
                begin
                    conflict_next = 1'b1;
                    fin           = 1'b1;
                    fin_st        = aicx_pkg::ST_CONFLICT;
                    state_next    = S_IDLE;
                end
                else
                begin
                    mem_we     = 1'b1;
                    waddr      = addr1;
                    wdata      = cmd_reg.entry;
                    state_next = S_WRB;
                end
            end

            // Thread-zero write of an SMT insert
            S_WRB:
            begin
                mem_we     = 1'b1;
                waddr      = addr0;
                wdata      = cmd_reg.entry;
                fin        = 1'b1;
                state_next = S_IDLE;
            end
        endcase

        // Load the result register
        if (fin)
        begin
            ov_next    = 1'b1;
            st_next    = fin_st;
            cid_next   = (fin_cmd.op == aicx_pkg::REQ_INSERT && !fin_cmd.plat_err)
                       ? fin_cmd.addr : 32'd0;
            act_next   = !conflict_next;
            done_next  = (fin_cmd.op == aicx_pkg::REQ_LOOKUP) && fin_cmd.last;
            cmask_next = (fin_cmd.op == aicx_pkg::REQ_LOOKUP && fin_st != aicx_pkg::ST_OK)
                       ? 64'd0 : mask_next;
            if (fin_cmd.op == aicx_pkg::REQ_LOOKUP && fin_cmd.last)
            begin
                mask_next = 64'd0;
                lerr_next = aicx_pkg::ST_OK;
            end
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_SWEEP;
            sweep_reg    <= '0;
            sw_clr_reg   <= 1'b0;
            init_reg     <= 1'b1;
            conflict_reg <= 1'b0;
            mask_reg     <= '0;
            lerr_reg     <= aicx_pkg::ST_OK;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            sw_clr_reg   <= sw_clr_next;
            init_reg     <= init_next;
            conflict_reg <= conflict_next;
            mask_reg     <= mask_next;
            lerr_reg     <= lerr_next;
            ov_reg       <= ov_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        st_reg    <= st_next;
        cid_reg   <= cid_next;
        cmask_reg <= cmask_next;
        act_reg   <= act_next;
        done_reg  <= done_next;
    end

    assign q_ready       = pop;
    assign init_busy     = init_reg;
    assign out_valid     = ov_reg;
    assign status        = st_reg;
    assign computed_id   = cid_reg;
    assign complex_mask  = cmask_reg;
    assign activation_ok = act_reg;
    assign list_done     = done_reg;

endmodule

/* rtl/apic_id_to_ccx_table_engine_top.sv */
// Top level of the APIC ID to complex table engine: front, queue and back.
// Depends on aicx_pkg, aicx_front, aicx_queue and aicx_back.
//
//   channel   handshake             payload
//   -------   -------------------   ---------------------------------------------
//   input     in_valid / in_ready   req_type core_info phys_complex id_index
//                                   peer_entry peer_disabled last
//   output    out_valid / out_ready status computed_id complex_mask activation_ok
//                                   list_done
//   config    cfg_valid / cfg_ready cfg_index cfg_data
//
// Lookup, merge and plain insert run as queue pop with table read, read data check
// with write, then result register; an SMT insert does two reads, then two writes.
// Clear sweeps the whole table. After reset a clearing pass zeroes the table;
// in_ready is low meanwhile, cfg_ready stays high. The queue keeps taking items
// while a result waits on out_ready; the back end starts a new item only once the
// result is taken.
module apic_id_to_ccx_table_engine_top #(
    parameter int TABLE_DEPTH = aicx_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [aicx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     req_type,
    input  logic [31:0]                    core_info,
    input  logic [3:0]                     phys_complex,
    input  logic [31:0]                    id_index,
    input  logic [7:0]                     peer_entry,
    input  logic                           peer_disabled,
    input  logic                           last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [2:0]                     status,
    output logic [31:0]                    computed_id,
    output logic [63:0]                    complex_mask,
    output logic                           activation_ok,
    output logic                           list_done
);

    aicx_pkg::cmd_t front_cmd;
    aicx_pkg::cmd_t q_cmd;
    logic           q_push_ready;
    logic           q_valid;
    logic           q_pop;
    logic           init_busy;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    // Hold off items during the clearing pass after reset
    assign in_ready = q_push_ready && !init_busy;

    aicx_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_type      (req_type),
        .core_info     (core_info),
        .phys_complex  (phys_complex),
        .id_index      (id_index),
        .peer_entry    (peer_entry),
        .peer_disabled (peer_disabled),
        .last          (last),
        .cmd           (front_cmd)
    );

    aicx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid && !init_busy),
        .push_ready (q_push_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_cmd    (q_cmd)
    );

    aicx_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_ready       (q_pop),
        .q_cmd         (q_cmd),
        .init_busy     (init_busy),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .computed_id   (computed_id),
        .complex_mask  (complex_mask),
        .activation_ok (activation_ok),
        .list_done     (list_done)
    );

    // A new item leaves the queue only when no result is pending
    a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !out_valid)
        else $error("queue popped while a result was pending");

    // Every conflict answer comes with the sticky conflict set
    a_conflict_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == aicx_pkg::ST_CONFLICT) |-> !activation_ok)
        else $error("conflict status with activation_ok high");

    // A failed lookup list reports an empty mask
    a_err_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && list_done && status != aicx_pkg::ST_OK) |-> complex_mask == 64'd0)
        else $error("lookup error with nonzero mask");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the APIC ID to complex table engine.
// Depends on aicx_pkg and apic_id_to_ccx_table_engine_top; predicts every result in-line.
module tb_top;

    import aicx_pkg::*;

    localparam int TBL_DEPTH   = TABLE_DEPTH_DEF;
    localparam int HOLD_CYCLES = 300;

    // Register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_RSVD_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RSVD_B = 2'd3;

    typedef struct {
        req_t        op;
        logic [31:0] core_info;
        logic [3:0]  pcx;
        logic [31:0] idx;
        logic [7:0]  peer;
        logic        dis;
        logic        last;
    } table_req_t;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] cid;
        logic [63:0] mask;
        logic        act;
        logic        done;
    } table_resp_t;

    typedef struct {
        int unsigned core_sh;
        int unsigned ccx_sh;
        int unsigned die_sh;
        int unsigned sock_sh;
        bit          ok;
    } id_layout_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = '0;
    logic [31:0] core_info = '0;
    logic [3:0]  phys_complex = '0;
    logic [31:0] id_index = '0;
    logic [7:0]  peer_entry = '0;
    logic        peer_disabled = 1'b0;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [31:0] computed_id;
    logic [63:0] complex_mask;
    logic        activation_ok;
    logic        list_done;

    // Shadow state of the table engine
    logic [31:0] topo_cfg = '0;
    logic        smt_cfg = 1'b0;
    logic [7:0]  id_tbl [TBL_DEPTH];
    logic        conflict_flag = 1'b0;
    logic [63:0] lookup_mask = '0;
    logic [2:0]  list_err = ST_OK;

    table_req_t  req_backlog [$];
    table_resp_t expected_resp [$];
    int unsigned fail_count = 0;

    // Sender and receiver pacing
    table_req_t  cur_req;
    int unsigned gap_left = 0;
    int unsigned burst_left = 1;
    logic [15:0] stall_pattern = 16'hFFFF;
    int unsigned pattern_left = 0;
    int unsigned hold_left = 0;
    logic        hold_go = 1'b0;
    table_resp_t want;

    apic_id_to_ccx_table_engine_top #(
        .TABLE_DEPTH(TBL_DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .core_info    (core_info),
        .phys_complex (phys_complex),
        .id_index     (id_index),
        .peer_entry   (peer_entry),
        .peer_disabled(peer_disabled),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .computed_id  (computed_id),
        .complex_mask (complex_mask),
        .activation_ok(activation_ok),
        .list_done    (list_done)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            id_tbl[i] = '0;
        end
    end

    function automatic int unsigned bit_len(input logic [31:0] v);
        int unsigned n;
        n = 0;
        while (v != 0)
        begin
            n++;
            v >>= 1;
        end
        return n;
    endfunction

    // Field positions of an APIC ID under the current topology and SMT setting
    function automatic id_layout_t decode_topology();
        id_layout_t  f;
        int unsigned bp;
        f.core_sh = 0;
        f.ccx_sh  = 0;
        f.die_sh  = 0;
        f.sock_sh = 0;
        f.ok      = 1'b0;
        bp = smt_cfg ? 1 : 0;
        if (topo_cfg != 0)
        begin
            f.core_sh = bp;
            bp += bit_len(topo_cfg[19:16]);
            if (topo_cfg[11] && bp < 4)
                bp = 4;
            f.ccx_sh = bp;
            bp += bit_len(topo_cfg[20]);
            f.die_sh = bp;
            bp += bit_len(topo_cfg[24:21]);
            f.sock_sh = bp;
            bp += bit_len(topo_cfg[26:25]);
            f.ok = (bp < 32);
        end
        return f;
    endfunction

    // Thread-zero ID of a per-core word
    function automatic logic [31:0] compose_id(input logic [31:0] info, input id_layout_t f);
        logic [31:0] id;
        id = ({28'd0, info[17:14]} << f.core_sh) | ({28'd0, info[22:19]} << f.die_sh)
           | ({30'd0, info[13:12]} << f.sock_sh);
        if (topo_cfg[20])
            id |= {31'd0, info[18]} << f.ccx_sh;
        return id;
    endfunction

    function automatic logic [31:0] pack_topology(input int unsigned sock_max,
                                                  input int unsigned die_max,
                                                  input int unsigned ccx_max,
                                                  input int unsigned core_max,
                                                  input int unsigned pad);
        logic [31:0] w;
        w = '0;
        w[26:25] = sock_max;
        w[24:21] = die_max;
        w[20]    = ccx_max;
        w[19:16] = core_max;
        w[11]    = pad;
        return w;
    endfunction

    // Advance the shadow table by one accepted item and queue its result
    task automatic predict_table_op(input table_req_t r);
        id_layout_t  f;
        table_resp_t res;
        logic [31:0] id0;
        logic [31:0] id1;
        logic [7:0]  ent;
        logic [6:0]  cx;
        res.status = ST_OK;
        res.cid    = '0;
        res.done   = 1'b0;
        f = decode_topology();
        case (r.op)
            REQ_CLEAR:
            begin
                if (f.ok)
                begin
                    for (int i = 0; i < TBL_DEPTH; i++)
                        id_tbl[i] = '0;
                    conflict_flag = 1'b0;
                end
                else
                    res.status = ST_PLATFORM;
            end
            REQ_INSERT:
            begin
                if (!f.ok)
                    res.status = ST_PLATFORM;
                else if (r.core_info[17:14] > topo_cfg[19:16]
                         || r.core_info[22:19] > topo_cfg[24:21])
                    res.status = ST_PLATFORM;
                else
                begin
                    id0 = compose_id(r.core_info, f);
                    id1 = id0 | 32'd1;
                    res.cid = id0;
                    ent = ENTRY_VALID | {2'b00, r.core_info[13:12], r.pcx};
                    if (conflict_flag)
                        res.status = ST_CONFLICT;
                    else if (id0 >= 32'(TBL_DEPTH) || id_tbl[id0] != 0)
                    begin
                        conflict_flag = 1'b1;
                        res.status = ST_CONFLICT;
                    end
                    else if (smt_cfg && (id1 >= 32'(TBL_DEPTH) || id_tbl[id1] != 0))
                    begin
                        conflict_flag = 1'b1;
                        res.status = ST_CONFLICT;
                    end
                    else
                    begin
                        if (smt_cfg)
                            id_tbl[id1] = ent;
                        id_tbl[id0] = ent;
                    end
                end
            end
            REQ_MERGE:
            begin
                if (r.dis)
                begin
                    conflict_flag = 1'b1;
                    res.status = ST_CONFLICT;
                end
                else if (conflict_flag)
                    res.status = ST_CONFLICT;
                else if (r.idx >= 32'(TBL_DEPTH))
                    res.status = ST_PARAMS;
                else if (r.peer != 0)
                begin
                    if (id_tbl[r.idx] != 0)
                    begin
                        conflict_flag = 1'b1;
                        res.status = ST_CONFLICT;
                    end
                    else
                        id_tbl[r.idx] = r.peer;
                end
            end
            default:
            begin
                // Lookup: first error of a list sticks until its last ID
                if (list_err == ST_OK)
                begin
                    if (r.idx >= 32'(TBL_DEPTH))
                        list_err = ST_PARAMS;
                    else if ((id_tbl[r.idx] & ENTRY_VALID) == 0)
                        list_err = ST_ENTRY;
                    else
                    begin
                        cx = id_tbl[r.idx][6:0];
                        if (cx < 64)
                            lookup_mask |= 64'd1 << cx;
                    end
                end
                res.status = list_err;
                res.done   = r.last;
            end
        endcase
        res.mask = lookup_mask;
        if (r.op == REQ_LOOKUP)
        begin
            if (res.status != ST_OK)
                res.mask = '0;
            if (r.last)
            begin
                lookup_mask = '0;
                list_err = ST_OK;
            end
        end
        res.act = !conflict_flag;
        expected_resp.push_back(res);
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, exp_val);
        fail_count++;
    endtask

    task automatic push_item(input req_t op, input logic [31:0] info, input logic [3:0] pcx,
                             input logic [31:0] idx, input logic [7:0] peer, input logic dis,
                             input logic lst);
        table_req_t r;
        r.op        = op;
        r.core_info = info;
        r.pcx       = pcx;
        r.idx       = idx;
        r.peer      = peer;
        r.dis       = dis;
        r.last      = lst;
        req_backlog.push_back(r);
    endtask

    task automatic write_cfg_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_TOPOLOGY: topo_cfg = data;
            CFG_SMT:      smt_cfg = data[0];
            default:      ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (req_backlog.size() != 0 || in_valid || expected_resp.size() != 0)
            @(negedge clk);
    endtask

    // New setting between phases, with a stray write to an undecoded index
    task automatic reconfigure(input logic [31:0] topo, input logic smt);
        wait_idle();
        repeat (8) @(posedge clk);
        write_cfg_reg(($urandom_range(0, 1) != 0) ? CFG_RSVD_A : CFG_RSVD_B, $urandom);
        write_cfg_reg(CFG_TOPOLOGY, topo);
        write_cfg_reg(CFG_SMT, {31'd0, smt});
        @(negedge clk);
    endtask

    // Random traffic: mostly table builds followed by lookup lists, some merges, some noise
    task automatic gen_random_items(input int unsigned count);
        int unsigned made;
        int unsigned kind;
        int unsigned n;
        int unsigned len;
        int unsigned tries;
        logic [31:0] info;
        logic [31:0] id0;
        logic [31:0] idx;
        logic [7:0]  peer;
        logic [31:0] ids [$];
        bit          used_ids [logic [31:0]];
        id_layout_t  f;
        made = 0;
        f = decode_topology();
        while (made < count)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    push_item(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom, 1'b0, 1'b0);
                    used_ids.delete();
                    ids.delete();
                    made++;
                end
                n = $urandom_range(1, 10);
                repeat (n)
                begin
                    tries = 0;
                    do
                    begin
                        info = $urandom;
                        if ($urandom_range(0, 9) != 0)
                        begin
                            info[17:14] = $urandom_range(0, topo_cfg[19:16]);
                            info[22:19] = $urandom_range(0, topo_cfg[24:21]);
                        end
                        id0 = compose_id(info, f);
                        tries++;
                    end
                    while (used_ids.exists(id0) && tries < 4);
                    used_ids[id0] = 1'b1;
                    ids.push_back(id0);
                    if (smt_cfg)
                        ids.push_back(id0 | 32'd1);
                    push_item(REQ_INSERT, info, $urandom, $urandom, $urandom, 1'b0, 1'b0);
                    made++;
                end
                n = $urandom_range(1, 3);
                repeat (n)
                begin
                    len = $urandom_range(1, 6);
                    for (int k = 0; k < len; k++)
                    begin
                        kind = $urandom_range(0, 19);
                        if (kind < 16 && ids.size() != 0)
                            idx = ids[$urandom_range(0, ids.size() - 1)];
                        else if (kind < 19)
                            idx = $urandom_range(0, TBL_DEPTH - 1);
                        else
                            idx = $urandom;
                        push_item(REQ_LOOKUP, $urandom, $urandom, idx, $urandom, $urandom,
                                  k == len - 1);
                        made++;
                    end
                end
            end
            else if (kind < 85)
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    idx = ($urandom_range(0, 6) != 0) ? $urandom_range(0, TBL_DEPTH - 1)
                                                      : $urandom;
                    kind = $urandom_range(0, 9);
                    if (kind < 3)
                        peer = '0;
                    else if (kind < 7)
                        peer = ENTRY_VALID | 8'($urandom_range(0, 63));
                    else
                        peer = $urandom;
                    ids.push_back(idx);
                    push_item(REQ_MERGE, $urandom, $urandom, idx, peer,
                              $urandom_range(0, 19) == 0, $urandom);
                    made++;
                end
            end
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    kind = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                       : $urandom_range(1, 3);
                    push_item(req_t'(kind), $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom);
                    made++;
                end
            end
        end
    endtask

    // Driver: bursts of items with random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_table_op(cur_req);
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0 || req_backlog.size() == 0)
                begin
                    if (gap_left != 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    cur_req = req_backlog.pop_front();
                    in_valid      <= 1'b1;
                    req_type      <= cur_req.op;
                    core_info     <= cur_req.core_info;
                    phys_complex  <= cur_req.pcx;
                    id_index      <= cur_req.idx;
                    peer_entry    <= cur_req.peer;
                    peer_disabled <= cur_req.dis;
                    last          <= cur_req.last;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: check each result, then pick the next ready value from a rotating pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_resp.size() == 0)
                    report_mismatch("unexpected item", 64'(status), '0);
                else
                begin
                    want = expected_resp.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", 64'(status), 64'(want.status));
                    if (computed_id !== want.cid)
                        report_mismatch("computed_id", 64'(computed_id), 64'(want.cid));
                    if (complex_mask !== want.mask)
                        report_mismatch("complex_mask", complex_mask, want.mask);
                    if (activation_ok !== want.act)
                        report_mismatch("activation_ok", 64'(activation_ok), 64'(want.act));
                    if (list_done !== want.done)
                        report_mismatch("list_done", 64'(list_done), 64'(want.done));
                end
            end
            if (pattern_left == 0)
            begin
                stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom) | 16'h1;
                pattern_left = 64;
            end
            else
            begin
                stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
                pattern_left--;
            end
            out_ready <= (hold_left == 0) && stall_pattern[0];
        end
    end

    // Run limit
    initial
    begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

    // Stimulus sequence
    initial
    begin
        logic [31:0] rand_topo;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // No topology: clear and insert refuse, merge and lookup still work
        reconfigure(32'h0, 1'b0);
        push_item(REQ_CLEAR, 32'h0, 4'h0, 32'h0, 8'h00, 1'b0, 1'b0);
        push_item(REQ_INSERT, 32'hFFFF_FFFF, 4'hF, 32'h0, 8'h00, 1'b0, 1'b0);
        push_item(REQ_LOOKUP, 32'h0, 4'h0, 32'h0, 8'h00, 1'b0, 1'b0);
        push_item(REQ_LOOKUP, 32'h0, 4'h0, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1);
        push_item(REQ_MERGE, 32'h0, 4'h0, 32'd5, 8'h85, 1'b0, 1'b0);
        push_item(REQ_LOOKUP, 32'h0, 4'h0, 32'd5, 8'h00, 1'b0, 1'b1);
        gen_random_items(150);

        // SMT with 16-thread padding
        reconfigure(pack_topology(1, 1, 1, 3, 1), 1'b1);
        push_item(REQ_CLEAR, 32'h0, 4'h0, 32'h0, 8'h00, 1'b0, 1'b0);
        push_item(REQ_INSERT, 32'h0, 4'hF, 32'h0, 8'h00, 1'b0, 1'b0);
        // collision, then inserts and merges answer conflict until a clear
        push_item(REQ_INSERT, 32'h0, 4'h3, 32'h0, 8'h00, 1'b0, 1'b0);
        push_item(REQ_MERGE, 32'h0, 4'h0, 32'd9, 8'h81, 1'b0, 1'b0);
        // core index above its maximum wins over the conflict
        push_item(REQ_INSERT, 32'h0003_C000, 4'h0, 32'h0, 8'h00, 1'b0, 1'b0);
        push_item(REQ_CLEAR, 32'h0, 4'h0, 32'h0, 8'h00, 1'b0, 1'b0);
        push_item(REQ_INSERT, 32'h000C_D000, 4'h0, 32'h0, 8'h00, 1'b0, 1'b0);
        push_item(REQ_INSERT, 32'h0010_0000, 4'h0, 32'h0, 8'h00, 1'b0, 1'b0);
        push_item(REQ_MERGE, 32'h0, 4'h0, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b0);
        push_item(REQ_MERGE, 32'h0, 4'h0, 32'd200, 8'h00, 1'b0, 1'b0);
        // complex number of 64 or more contributes no mask bit
        push_item(REQ_MERGE, 32'h0, 4'h0, 32'd200, 8'hFF, 1'b0, 1'b0);
        push_item(REQ_LOOKUP, 32'h0, 4'h0, 32'd200, 8'h00, 1'b0, 1'b0);
        push_item(REQ_LOOKUP, 32'h0, 4'h0, 32'd118, 8'h00, 1'b0, 1'b0);
        push_item(REQ_LOOKUP, 32'h0, 4'h0, 32'd119, 8'h00, 1'b0, 1'b1);
        push_item(REQ_LOOKUP, 32'h0, 4'h0, 32'd512, 8'h00, 1'b0, 1'b0);
        push_item(REQ_LOOKUP, 32'h0, 4'h0, 32'd118, 8'h00, 1'b0, 1'b1);
        push_item(REQ_MERGE, 32'h0, 4'h0, 32'd118, 8'h81, 1'b0, 1'b0);
        push_item(REQ_MERGE, 32'h0, 4'h0, 32'd3, 8'h00, 1'b1, 1'b0);
        push_item(REQ_CLEAR, 32'h0, 4'h0, 32'h0, 8'h00, 1'b0, 1'b0);
        gen_random_items(250);
        // receiver backs off while the sender keeps offering
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;

        reconfigure(32'hFFFF_FFFF, 1'b1);
        gen_random_items(150);
        reconfigure(pack_topology(3, 3, 1, 7, 0), 1'b0);
        gen_random_items(250);
        reconfigure(pack_topology(0, 0, 0, 0, 1), 1'b0);
        gen_random_items(100);
        repeat (3)
        begin
            rand_topo = $urandom;
            rand_topo[26:25] = $urandom_range(0, 1);
            rand_topo[24:21] = $urandom_range(0, 3);
            rand_topo[19:16] = $urandom_range(0, 7);
            reconfigure(rand_topo, $urandom_range(0, 1));
            gen_random_items(250);
        end

        wait_idle();
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/aicx_pkg.sv
rtl/aicx_front.sv
rtl/aicx_queue.sv
rtl/aicx_back.sv
rtl/apic_id_to_ccx_table_engine_top.sv
tb/tb_top.sv
